// ===== hw/rtl/i2cdw_pkg.sv =====
// Shared types and constants for the display write I2C master.
package i2cdw_pkg;

  typedef struct packed {
    logic       start_req;
    logic       is_data;
    logic [7:0] payload;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [7:0] {
    PhIdle       = 8'b0000_0001,
    PhStartSetup = 8'b0000_0010,
    PhStartHold  = 8'b0000_0100,
    PhBitLow     = 8'b0000_1000,
    PhBitHigh    = 8'b0001_0000,
    PhStopLow    = 8'b0010_0000,
    PhStopHigh   = 8'b0100_0000,
    PhDone       = 8'b1000_0000
  } phase_e;

  localparam logic       CfgDevAddr    = 1'b0;
  localparam logic       CfgHalfPeriod = 1'b1;

  localparam logic [7:0] DevAddrReset    = 8'd120;
  localparam logic [9:0] HalfPeriodReset = 10'd20;

  localparam logic [7:0] CtrlCmd  = 8'h00;
  localparam logic [7:0] CtrlData = 8'h40;

  localparam logic [1:0] ByteAddr    = 2'd0;
  localparam logic [1:0] ByteCtrl    = 2'd1;
  localparam logic [1:0] BytePayload = 2'd2;

  localparam logic [3:0] AckBit = 4'd8;

endpackage

// ===== hw/rtl/i2cdw_seq.sv =====
// Bit-level bus sequencer: state registers, one tick per beat.
module i2cdw_seq import i2cdw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_item_t   item_i,
  input  logic [7:0] dev_addr_i,
  input  logic [9:0] half_period_i,
  output out_item_t  result_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] bit_idx_q, bit_idx_d;
  logic [1:0] byte_idx_q, byte_idx_d;
  logic [7:0] shift_q, shift_d;
  logic [9:0] tick_q, tick_d;
  logic [7:0] held_pay_q, held_pay_d;
  logic       held_isd_q, held_isd_d;
  logic [1:0] err_q, err_d;

  logic [9:0]  hp;
  logic [10:0] tick_inc;
  logic        hp_end;

  function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic [7:0] dev,
                                          input logic isd, input logic [7:0] pay);
    logic [7:0] b;
    if (idx == ByteAddr) begin
      b = dev;
    end else if (idx == ByteCtrl) begin
      b = isd ? CtrlData : CtrlCmd;
    end else begin
      b = pay;
    end
    return b;
  endfunction

  // Outputs reflect the state held at the start of the tick.
  always_comb begin
    result_o = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b1, done_res: 1'b0, status: 2'd0};
    unique case (phase_q)
      PhStartSetup: ;
      PhStartHold:  result_o.sda_out = 1'b0;
      PhBitLow, PhBitHigh: begin
        result_o.scl_out = (phase_q == PhBitHigh);
        result_o.sda_out = (bit_idx_q >= AckBit) ? 1'b1 : shift_q[7];
      end
      PhStopLow: begin
        result_o.scl_out = 1'b0;
        result_o.sda_out = 1'b0;
      end
      PhStopHigh:   result_o.sda_out = 1'b0;
      PhDone: begin
        result_o.busy_res = 1'b0;
        result_o.done_res = 1'b1;
        result_o.status   = err_q;
      end
      default:      result_o.busy_res = 1'b0;
    endcase
  end

  assign hp       = (half_period_i == 10'd0) ? 10'd1 : half_period_i;
  assign tick_inc = {1'b0, tick_q} + 11'd1;
  assign hp_end   = tick_inc >= {1'b0, hp};

  always_comb begin
    phase_d    = phase_q;
    bit_idx_d  = bit_idx_q;
    byte_idx_d = byte_idx_q;
    shift_d    = shift_q;
    tick_d     = tick_q;
    held_pay_d = held_pay_q;
    held_isd_d = held_isd_q;
    err_d      = err_q;
    if (phase_q == PhIdle || phase_q == PhDone) begin
      tick_d  = 10'd0;
      phase_d = PhIdle;
      if (phase_q == PhIdle && item_i.start_req) begin
        held_pay_d = item_i.payload;
        held_isd_d = item_i.is_data;
        err_d      = 2'd0;
        byte_idx_d = ByteAddr;
        bit_idx_d  = 4'd0;
        shift_d    = 8'd0;
        phase_d    = PhStartSetup;
      end
    end else if (!hp_end) begin
      tick_d = tick_inc[9:0];
    end else begin
      tick_d = 10'd0;
      unique case (phase_q)
        PhStartSetup: phase_d = PhStartHold;
        PhStartHold: begin
          byte_idx_d = ByteAddr;
          bit_idx_d  = 4'd0;
          shift_d    = dev_addr_i;
          phase_d    = PhBitLow;
        end
        PhBitLow: phase_d = PhBitHigh;
        PhBitHigh: begin
          priority if (bit_idx_q < AckBit) begin
            shift_d   = {shift_q[6:0], 1'b0};
            bit_idx_d = bit_idx_q + 4'd1;
            phase_d   = PhBitLow;
          end else if (item_i.sda_in) begin
            // NACK: record which byte failed, then close with STOP
            err_d   = byte_idx_q + 2'd1;
            phase_d = PhStopLow;
          end else if (byte_idx_q >= BytePayload) begin
            phase_d = PhStopLow;
          end else begin
            byte_idx_d = byte_idx_q + 2'd1;
            bit_idx_d  = 4'd0;
            shift_d    = byte_for(byte_idx_q + 2'd1, dev_addr_i, held_isd_q, held_pay_q);
            phase_d    = PhBitLow;
          end
        end
        PhStopLow: phase_d = PhStopHigh;
        default:   phase_d = PhDone;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      bit_idx_q  <= 4'd0;
      byte_idx_q <= 2'd0;
      shift_q    <= 8'd0;
      tick_q     <= 10'd0;
      held_pay_q <= 8'd0;
      held_isd_q <= 1'b0;
      err_q      <= 2'd0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      bit_idx_q  <= bit_idx_d;
      byte_idx_q <= byte_idx_d;
      shift_q    <= shift_d;
      tick_q     <= tick_d;
      held_pay_q <= held_pay_d;
      held_isd_q <= held_isd_d;
      err_q      <= err_d;
    end
  end

endmodule

// ===== hw/rtl/i2c_display_write_master_core.sv =====
// Top level of the display write I2C master: config registers, sequencer, result register.
//
//   channel   direction  handshake                payload
//   in        input      in_valid_i / in_stall_o  in_item_i  (in_item_t)
//   out       output     out_valid_o / out_stall_i out_item_o (out_item_t)
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each beat is one bus tick; one beat in and one result out every cycle while no result is held under out_stall_i.
// The result of a beat appears in the cycle after acceptance, from the result register.
// The sequencer state advances only on accepted beats, so stalls just pause the bus.
// A result held under out_stall_i blocks new input; one being taken does not.
// Reset puts the sequencer in idle and the config registers at their defaults.
module i2c_display_write_master_core import i2cdw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [9:0] cfg_data_i
);

  logic [7:0] dev_addr_q;
  logic [9:0] half_period_q;
  logic       out_valid_q;
  out_item_t  out_item_q;
  out_item_t  seq_result;
  logic       accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DevAddrReset;
      half_period_q <= HalfPeriodReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDevAddr:    dev_addr_q    <= cfg_data_i[7:0];
        CfgHalfPeriod: half_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  i2cdw_seq u_seq (
    .clk_i,
    .rst_ni,
    .step_i        (accept),
    .item_i        (in_item_i),
    .dev_addr_i    (dev_addr_q),
    .half_period_i (half_period_q),
    .result_o      (seq_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= seq_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the display write I2C master: bus levels predicted per tick.
module testbench import i2cdw_pkg::*;;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StAddrNack = 2'd1;
  localparam logic [1:0] StCtrlNack = 2'd2;
  localparam logic [1:0] StPayNack  = 2'd3;

  localparam int MaxGap = 14;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  in_item_t   in_item   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_index = CfgDevAddr;
  logic [9:0] cfg_data  = '0;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_ready;

  i2c_display_write_master_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Sequencer mirror, advanced once per accepted beat
  phase_e     seq_phase       = PhIdle;
  logic [3:0] seq_bit         = '0;
  logic [1:0] seq_byte        = ByteAddr;
  logic [7:0] seq_shift       = '0;
  logic [9:0] seq_ticks       = '0;
  logic [7:0] seq_payload     = '0;
  logic       seq_is_data     = 1'b0;
  logic [1:0] seq_status      = StOk;
  logic [7:0] reg_dev_addr    = DevAddrReset;
  logic [9:0] reg_half_period = HalfPeriodReset;

  out_item_t pending_levels[$];

  int  errors     = 0;
  int  beats_sent = 0;
  int  transfers  = 0;
  int  nacks      = 0;
  int  rx_hold    = 0;
  bit  tx_idle    = 1'b1;
  bit  rx_idle    = 1'b1;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] byte_on_wire(logic [1:0] which);
    if (which == ByteAddr) return reg_dev_addr;
    if (which == ByteCtrl) return seq_is_data ? CtrlData : CtrlCmd;
    return seq_payload;
  endfunction

  function automatic logic [1:0] nack_status(logic [1:0] which);
    case (which)
      ByteAddr: return StAddrNack;
      ByteCtrl: return StCtrlNack;
      default:  return StPayNack;
    endcase
  endfunction

  // Levels shown for this tick come from the state held before it advances
  function automatic out_item_t next_bus_levels(in_item_t it);
    out_item_t   lv;
    int unsigned hp;
    lv.scl_out  = 1'b1;
    lv.sda_out  = 1'b1;
    lv.busy_res = 1'b1;
    lv.done_res = 1'b0;
    lv.status   = StOk;
    hp = (reg_half_period == '0) ? 1 : reg_half_period;
    case (seq_phase)
      PhStartSetup: ;
      PhStartHold: lv.sda_out = 1'b0;
      PhBitLow, PhBitHigh: begin
        lv.scl_out = (seq_phase == PhBitHigh);
        lv.sda_out = (seq_bit >= AckBit) ? 1'b1 : seq_shift[7];
      end
      PhStopLow: begin
        lv.scl_out = 1'b0;
        lv.sda_out = 1'b0;
      end
      PhStopHigh: lv.sda_out = 1'b0;
      PhDone: begin
        lv.busy_res = 1'b0;
        lv.done_res = 1'b1;
        lv.status   = seq_status;
      end
      default: lv.busy_res = 1'b0;
    endcase

    if (seq_phase == PhIdle || seq_phase == PhDone) begin
      if (seq_phase == PhIdle && it.start_req) begin
        seq_payload = it.payload;
        seq_is_data = it.is_data;
        seq_status  = StOk;
        seq_byte    = ByteAddr;
        seq_bit     = '0;
        seq_shift   = '0;
        seq_phase   = PhStartSetup;
      end else begin
        seq_phase = PhIdle;
      end
      seq_ticks = '0;
    end else if (seq_ticks + 1 < hp) begin
      seq_ticks = seq_ticks + 1'b1;
    end else begin
      seq_ticks = '0;
      case (seq_phase)
        PhStartSetup: seq_phase = PhStartHold;
        PhStartHold: begin
          seq_byte  = ByteAddr;
          seq_bit   = '0;
          seq_shift = byte_on_wire(ByteAddr);
          seq_phase = PhBitLow;
        end
        PhBitLow: seq_phase = PhBitHigh;
        PhBitHigh: begin
          if (seq_bit < AckBit) begin
            seq_shift = seq_shift << 1;
            seq_bit   = seq_bit + 1'b1;
            seq_phase = PhBitLow;
          end else if (it.sda_in) begin
            seq_status = nack_status(seq_byte);
            seq_phase  = PhStopLow;
          end else if (seq_byte >= BytePayload) begin
            seq_phase = PhStopLow;
          end else begin
            seq_byte  = seq_byte + 1'b1;
            seq_bit   = '0;
            seq_shift = byte_on_wire(seq_byte);
            seq_phase = PhBitLow;
          end
        end
        PhStopLow: seq_phase = PhStopHigh;
        default:   seq_phase = PhDone;
      endcase
    end
    return lv;
  endfunction

  function automatic in_item_t pick_beat(int start_pct, int nack_pct);
    in_item_t it;
    it.start_req = ($urandom_range(0, 99) < start_pct);
    it.is_data   = 1'($urandom_range(0, 1));
    it.payload   = 8'($urandom_range(0, 255));
    if (seq_phase == PhBitHigh && seq_bit == AckBit)
      it.sda_in = ($urandom_range(0, 99) < nack_pct);
    else
      it.sda_in = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_beat(input in_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pending_levels.push_back(next_bus_levels(it));
    beats_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  // Write both registers back to back; the sequencer may be mid transfer
  task automatic load_settings(input logic [7:0] addr, input logic [9:0] hp);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CfgDevAddr;
    cfg_data  <= {2'($urandom_range(0, 3)), addr};
    do @(posedge clk); while (!cfg_ready);
    reg_dev_addr = addr;
    cfg_index <= CfgHalfPeriod;
    cfg_data  <= hp;
    do @(posedge clk); while (!cfg_ready);
    reg_half_period = hp;
    cfg_valid <= 1'b0;
  endtask

  // Finish any transfer under way, then run one with the chosen ack failure
  task automatic run_transfer(input logic isd, input logic [7:0] pay, input logic [1:0] nack_at);
    in_item_t it;
    while (seq_phase != PhIdle) send_beat(pick_beat(50, 0));
    it.start_req = 1'b1;
    it.is_data   = isd;
    it.payload   = pay;
    it.sda_in    = 1'($urandom_range(0, 1));
    send_beat(it);
    while (seq_phase != PhIdle) begin
      it = pick_beat(50, 0);
      if (seq_phase == PhBitHigh && seq_bit == AckBit && nack_at != StOk &&
          nack_status(seq_byte) == nack_at)
        it.sda_in = 1'b1;
      send_beat(it);
    end
  endtask

  task automatic test_reset_defaults();
    in_item_t it;
    it.start_req = 1'b1;
    it.is_data   = 1'b1;
    it.payload   = 8'hA5;
    it.sda_in    = 1'b0;
    send_beat(it);
    repeat (8) send_beat(pick_beat(50, 0));
    // shorten the half period while the count is still below the new end
    load_settings(reg_dev_addr, 10'd12);
    repeat (20) send_beat(pick_beat(50, 0));
    // and again with the count already past it
    load_settings(reg_dev_addr, 10'd2);
    repeat (12) send_beat(pick_beat(50, 0));
  endtask

  task automatic test_directed_transfers();
    load_settings(8'h00, 10'd1);
    run_transfer(1'b1, 8'hFF, StOk);
    run_transfer(1'b0, 8'h55, StAddrNack);
    load_settings(8'hFF, 10'd1);
    run_transfer(1'b0, 8'h80, StCtrlNack);
    run_transfer(1'b1, 8'h01, StPayNack);
    // zero half period runs as one tick
    load_settings(8'h3C, 10'd0);
    run_transfer(1'b1, 8'h7E, StOk);
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = 300;
    repeat (60) send_beat(pick_beat(80, 15));
    tx_idle = 1'b1;
  endtask

  task automatic test_longest_half_period();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    while (seq_phase != PhIdle) send_beat(pick_beat(0, 0));
    load_settings(8'hFF, 10'd1023);
    send_beat(pick_beat(100, 0));
    repeat (40) send_beat(pick_beat(50, 0));
    // drop to one tick with the count far past the new end
    load_settings(8'hFF, 10'd1);
    run_transfer(1'b0, 8'h3C, StOk);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [9:0] hps[6] = '{10'd1, 10'd2, 10'd1, 10'd3, 10'd0, 10'd1};
    for (int p = 0; p < 6; p++) begin
      load_settings((p == 0) ? 8'h00 : 8'($urandom_range(0, 255)), hps[p]);
      tx_idle = (p != 2);
      rx_idle = (p != 3);
      repeat (10) send_beat(pick_beat(85, 15));
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin : result_checker
    out_item_t got;
    out_item_t want;
    int        gap;
    @(posedge rst_n);
    forever begin
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, MaxGap) : 0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got = out_item;
      if (got.done_res) begin
        transfers++;
        if (got.status != StOk) nacks++;
      end
      if (pending_levels.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_levels.pop_front();
        if (got.scl_out !== want.scl_out) begin
          $error("scl_out expected %0b got %0b", want.scl_out, got.scl_out);
          errors++;
        end
        if (got.sda_out !== want.sda_out) begin
          $error("sda_out expected %0b got %0b", want.sda_out, got.sda_out);
          errors++;
        end
        if (got.busy_res !== want.busy_res) begin
          $error("busy_res expected %0b got %0b", want.busy_res, got.busy_res);
          errors++;
        end
        if (got.done_res !== want.done_res) begin
          $error("done_res expected %0b got %0b", want.done_res, got.done_res);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_transfers();
    test_backpressure();
    test_longest_half_period();
    test_random_traffic();
    wait_results_drained();
    repeat (10) @(posedge clk);
    $display("Run covered %0d bus ticks, %0d finished transfers, %0d with a missing ack,",
             beats_sent, transfers, nacks);
    $display("half periods from zero to 1023, address bytes 0x00 and 0xFF, long output stall.");
    if (errors == 0) begin
      $display("[i2c_display_write_master_core] OK");
    end else begin
      $display("[i2c_display_write_master_core] ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[i2c_display_write_master_core] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/i2cdw_pkg.sv
hw/rtl/i2cdw_seq.sv
hw/rtl/i2c_display_write_master_core.sv
test/testbench.sv
